@@ src/pqe_pkg.sv @@
`default_nettype none
package pqe_pkg;

   // Field and storage sizes
   localparam int ELEM_W         = 16;
   localparam int ADDR_W         = 16;
   localparam int OP_W           = 2;
   localparam int MAX_CHUNKS     = 32;
   localparam int MAX_SUB_DIM    = 8;
   localparam int CENTROID_COUNT = 256;
   localparam int CODE_W         = $clog2(CENTROID_COUNT);
   localparam int CHUNK_W        = $clog2(MAX_CHUNKS);
   localparam int POS_W          = $clog2(MAX_SUB_DIM);
   localparam int CB_DEPTH       = MAX_CHUNKS * CENTROID_COUNT * MAX_SUB_DIM;
   localparam int CT_DEPTH       = MAX_CHUNKS * MAX_SUB_DIM;
   localparam int CT_AW          = $clog2(CT_DEPTH);
   localparam int SUB_W          = ELEM_W + 1;
   localparam int DIFF_W         = ELEM_W + 2;
   localparam int SQ_W           = 2 * DIFF_W;
   localparam int DIST_W         = 40;

   // Configuration registers
   localparam int NC_W       = 6;
   localparam int CD_W       = 4;
   localparam int CSR_DW     = 32;
   localparam int CSR_AW     = 4;
   localparam int CSR_IDX_W  = CSR_AW - 2;
   localparam logic [NC_W-1:0] NC_RESET = 6'd8;
   localparam logic [CD_W-1:0] CD_RESET = 4'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_CHUNKS = 2'd0,
      CSR_SUB_DIM    = 2'd1,
      CSR_ZERO_MEAN  = 2'd2
   } csr_index_type;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_CODEBOOK = 2'd0,
      OP_LOAD_CENTER   = 2'd1,
      OP_ENCODE        = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELEM,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Effective (clamped) configuration
   typedef struct packed {
      logic [NC_W-1:0] nc_eff;
      logic [CD_W-1:0] cd_eff;
      logic            zero_mean;
   } cfg_type;

   // One codebook read issued to the distance datapath
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic [POS_W-1:0]  j;
      logic [CODE_W-1:0] c;
   } step_type;

   // Outcome of a centroid scan
   typedef struct packed {
      logic              done;
      logic [CODE_W-1:0] code;
      logic [DIST_W-1:0] best;
   } result_type;

endpackage
`default_nettype wire

@@ src/pqe_req_if.sv @@
`default_nettype none
interface pqe_req_if import pqe_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [ADDR_W-1:0]        addr;
   logic signed [ELEM_W-1:0] value;

   modport source (output valid, output op, output addr, output value, input ready);
   modport sink   (input valid, input op, input addr, input value, output ready);
endinterface
`default_nettype wire

@@ src/pqe_rsp_if.sv @@
`default_nettype none
interface pqe_rsp_if import pqe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  code;
   logic [CHUNK_W-1:0] chunk_index;
   logic [DIST_W-1:0]  best_distance;
   logic               last;

   modport source (output valid, output code, output chunk_index, output best_distance,
                   output last, input ready);
   modport sink   (input valid, input code, input chunk_index, input best_distance,
                   input last, output ready);
endinterface
`default_nettype wire

@@ src/pq_nearest_centroid_encoder.sv @@
`default_nettype none
// Load requests leave the block idle; an encode request that does not end a chunk passes through
// the element state back to idle. An encode request that ends a chunk then scans all 256
// centroids, drains the distance pipeline and registers its result; the next request waits for
// that, and longer while an earlier result still waits: the scan reads one word per cycle.
// Synchronous active-high reset clears counters and sets registers to 8, 4 and 0;
// codebook and center memories hold no reset value and get no clearing pass.
module pq_nearest_centroid_encoder import pqe_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   pqe_req_if.sink                req_chan,
   pqe_rsp_if.source              rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   cfg_type                 cfg;
   state_type               state_ff, state_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [CHUNK_W-1:0]      chunk_ff, chunk_in;
   logic [ADDR_W-1:0]       cb_addr_ff, cb_addr_in;
   logic [CODE_W-1:0]       cent_ff, cent_in;
   logic [POS_W-1:0]        j_ff, j_in;
   logic [ELEM_W-1:0]       value_ff, value_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]       rsp_code_ff, rsp_code_in;
   logic [CHUNK_W-1:0]      rsp_chunk_ff, rsp_chunk_in;
   logic [DIST_W-1:0]       rsp_dist_ff, rsp_dist_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept;
   logic                    emit;
   logic                    is_last;
   logic                    j_last;
   logic [CT_AW:0]          chunk_cd;
   logic [CT_AW:0]          ct_sum;
   logic [ADDR_W-1:0]       cb_base;
   logic                    cb_we, ct_we, ct_re, cb_re;
   logic [ELEM_W-1:0]       cb_rdata, ct_rdata;
   logic signed [SUB_W-1:0] elem;
   step_type                step;
   result_type              res;

   pqe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // Address arithmetic for the current chunk
   assign chunk_cd = (CT_AW+1)'(chunk_ff) * (CT_AW+1)'(cfg.cd_eff);
   assign ct_sum   = chunk_cd + (CT_AW+1)'(pos_ff);
   assign cb_base  = {chunk_cd[ADDR_W-CODE_W-1:0], {CODE_W{1'b0}}};
   assign is_last  = ((NC_W'(chunk_ff) + NC_W'(1)) >= cfg.nc_eff);
   assign j_last   = ((CD_W'(j_ff) + CD_W'(1)) == cfg.cd_eff);

   // Memory ports
   assign cb_we = accept && (req_chan.op == OP_LOAD_CODEBOOK);
   assign ct_we = accept && (req_chan.op == OP_LOAD_CENTER)
                  && (req_chan.addr[ADDR_W-1:CT_AW] == '0);
   assign ct_re = accept && (req_chan.op == OP_ENCODE);
   assign cb_re = (state_ff == ST_SCAN);

   pqe_ram #(.WIDTH(ELEM_W), .DEPTH(CB_DEPTH)) u_codebook (
      .clock (clock),
      .we    (cb_we),
      .waddr (req_chan.addr),
      .wdata (req_chan.value),
      .re    (cb_re),
      .raddr (cb_addr_ff),
      .rdata (cb_rdata)
   );

   pqe_ram #(.WIDTH(ELEM_W), .DEPTH(CT_DEPTH)) u_center (
      .clock (clock),
      .we    (ct_we),
      .waddr (req_chan.addr[CT_AW-1:0]),
      .wdata (req_chan.value),
      .re    (ct_re),
      .raddr (ct_sum[CT_AW-1:0]),
      .rdata (ct_rdata)
   );

   // Element, centered on the stored center when zero mean is set
   assign elem = {value_ff[ELEM_W-1], value_ff}
               - (cfg.zero_mean ? {ct_rdata[ELEM_W-1], ct_rdata} : '0);

   // Scan step toward the distance datapath
   assign step.valid = (state_ff == ST_SCAN);
   assign step.first = (j_ff == '0);
   assign step.last  = j_last;
   assign step.j     = j_ff;
   assign step.c     = cent_ff;

   pqe_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .cb_rdata (cb_rdata),
      .sub_we   (state_ff == ST_ELEM),
      .sub_idx  (pos_ff),
      .sub_data (elem),
      .res      (res)
   );

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      chunk_in   = chunk_ff;
      cb_addr_in = cb_addr_ff;
      cent_in    = cent_ff;
      j_in       = j_ff;
      emit       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_chan.op == OP_ENCODE)) begin
               state_in = ST_ELEM;
            end
         end
         ST_ELEM: begin
            if ((CD_W'(pos_ff) + CD_W'(1)) < cfg.cd_eff) begin
               pos_in   = pos_ff + POS_W'(1);
               state_in = ST_IDLE;
            end else begin
               cb_addr_in = cb_base;
               cent_in    = '0;
               j_in       = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cb_addr_in = cb_addr_ff + ADDR_W'(1);
            if (j_last) begin
               j_in    = '0;
               cent_in = cent_ff + CODE_W'(1);
               if (cent_ff == CODE_W'(CENTROID_COUNT - 1)) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               j_in = j_ff + POS_W'(1);
            end
         end
         ST_DRAIN: begin
            if (res.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               emit     = 1'b1;
               pos_in   = '0;
               chunk_in = is_last ? '0 : chunk_ff + CHUNK_W'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Capture the request value; load the output register
   always_comb begin
      value_in     = accept ? req_chan.value : value_ff;
      rsp_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      rsp_code_in  = emit ? res.code : rsp_code_ff;
      rsp_chunk_in = emit ? chunk_ff : rsp_chunk_ff;
      rsp_dist_in  = emit ? res.best : rsp_dist_ff;
      rsp_last_in  = emit ? is_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cb_addr_ff   <= cb_addr_in;
      cent_ff      <= cent_in;
      j_ff         <= j_in;
      value_ff     <= value_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_chunk_ff <= rsp_chunk_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.code          = rsp_code_ff;
   assign rsp_chan.chunk_index   = rsp_chunk_ff;
   assign rsp_chan.best_distance = rsp_dist_ff;
   assign rsp_chan.last          = rsp_last_ff;

endmodule
`default_nettype wire

@@ src/pqe_ram.sv @@
`default_nettype none
module pqe_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ src/pqe_csr.sv @@
`default_nettype none
module pqe_csr import pqe_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   logic [NC_W-1:0]      num_chunks_ff, num_chunks_in;
   logic [CD_W-1:0]      sub_dim_ff, sub_dim_in;
   logic                 zero_mean_ff, zero_mean_in;
   logic                 wr;
   logic [CSR_IDX_W-1:0] idx;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = paddr[CSR_AW-1:2];

   // Decode writes
   always_comb begin
      num_chunks_in = num_chunks_ff;
      sub_dim_in    = sub_dim_ff;
      zero_mean_in  = zero_mean_ff;
      if (wr) begin
         case (idx)
            CSR_NUM_CHUNKS: num_chunks_in = pwdata[NC_W-1:0];
            CSR_SUB_DIM:    sub_dim_in    = pwdata[CD_W-1:0];
            CSR_ZERO_MEAN:  zero_mean_in  = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_chunks_ff <= NC_RESET;
         sub_dim_ff    <= CD_RESET;
         zero_mean_ff  <= 1'b0;
      end else begin
         num_chunks_ff <= num_chunks_in;
         sub_dim_ff    <= sub_dim_in;
         zero_mean_ff  <= zero_mean_in;
      end
   end

   // Read back the raw values
   always_comb begin
      case (idx)
         CSR_NUM_CHUNKS: prdata = CSR_DW'(num_chunks_ff);
         CSR_SUB_DIM:    prdata = CSR_DW'(sub_dim_ff);
         CSR_ZERO_MEAN:  prdata = CSR_DW'(zero_mean_ff);
         default:        prdata = '0;
      endcase
   end

   // Clamp to the supported ranges
   always_comb begin
      if (num_chunks_ff == '0) begin
         cfg.nc_eff = NC_W'(1);
      end else if (num_chunks_ff > NC_W'(MAX_CHUNKS)) begin
         cfg.nc_eff = NC_W'(MAX_CHUNKS);
      end else begin
         cfg.nc_eff = num_chunks_ff;
      end
      if (sub_dim_ff == '0) begin
         cfg.cd_eff = CD_W'(1);
      end else if (sub_dim_ff > CD_W'(MAX_SUB_DIM)) begin
         cfg.cd_eff = CD_W'(MAX_SUB_DIM);
      end else begin
         cfg.cd_eff = sub_dim_ff;
      end
      cfg.zero_mean = zero_mean_ff;
   end

endmodule
`default_nettype wire

@@ src/pqe_dist.sv @@
`default_nettype none
module pqe_dist import pqe_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire step_type                 step,
   input  wire logic [ELEM_W-1:0]        cb_rdata,
   input  wire logic                     sub_we,
   input  wire logic [POS_W-1:0]         sub_idx,
   input  wire logic signed [SUB_W-1:0]  sub_data,
   output result_type                    res
);

   logic signed [SUB_W-1:0]  sub_ff [MAX_SUB_DIM];
   step_type                 tag1_ff, tag2_ff, tag3_ff;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [DIST_W-1:0]        acc_ff, acc_in;
   logic [DIST_W-1:0]        best_ff, best_in;
   logic [CODE_W-1:0]        code_ff, code_in;
   logic                     done_ff, done_in;
   logic signed [SUB_W-1:0]  sub_sel;
   logic [DIST_W-1:0]        sum;
   logic                     take;

   // Hold the sub-vector of the current chunk
   always_ff @(posedge clock) begin
      if (sub_we) begin
         sub_ff[sub_idx] <= sub_data;
      end
   end

   // Stage 1: difference against the codebook word
   assign sub_sel = sub_ff[tag1_ff.j];
   assign diff_in = {sub_sel[SUB_W-1], sub_sel}
                  - {{(DIFF_W-ELEM_W){cb_rdata[ELEM_W-1]}}, cb_rdata};

   // Stage 2: square
   assign sq_in = SQ_W'(diff_ff * diff_ff);

   // Stage 3: accumulate and keep the nearest centroid, lowest index on ties
   assign sum     = (tag3_ff.first ? '0 : acc_ff) + DIST_W'(sq_ff);
   assign acc_in  = tag3_ff.valid ? sum : acc_ff;
   assign take    = tag3_ff.valid && tag3_ff.last
                    && ((tag3_ff.c == '0) || (sum < best_ff));
   assign best_in = take ? sum : best_ff;
   assign code_in = take ? tag3_ff.c : code_ff;
   assign done_in = tag3_ff.valid && tag3_ff.last
                    && (tag3_ff.c == CODE_W'(CENTROID_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         tag1_ff <= step;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      best_ff <= best_in;
      code_ff <= code_in;
   end

   assign res.done = done_ff;
   assign res.code = code_ff;
   assign res.best = best_ff;

endmodule
`default_nettype wire
